>>> sv/set_assoc_cache_tag_model_macros.svh
// Assertion macros for the cache directory RTL.
`ifndef SET_ASSOC_CACHE_TAG_MODEL_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_MODEL_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SACT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SACT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sact_pkg.sv
// Shared constants and types for the cache directory.
`timescale 1ns / 1ps
package sact_pkg;

  localparam int MAX_SET_BITS_DEF  = 6;
  localparam int MAX_WAYS_DEF      = 8;
  localparam int COUNTER_WIDTH_DEF = 48;

  localparam int MAX_OFFSET_BITS = 16;
  localparam int ADDR_W          = 64;
  localparam int BLK_W           = MAX_OFFSET_BITS + 1;
  localparam int OUT_CNT_W       = 48;
  localparam int DIRTY_W         = 26;
  localparam int WAY_OUT_W       = 3;

  localparam int SET_BITS_W    = 3;
  localparam int OFFSET_BITS_W = 5;
  localparam int WAYS_USED_W   = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 3'd4;
  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 5'd4;
  localparam logic [WAYS_USED_W-1:0]   WAYS_USED_RST   = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS_USED   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_STORE = 1'b1
  } cmd_t;

  // Events handed from the sequencer to the statistics counters.
  typedef struct packed {
    logic hit_inc;
    logic miss_inc;
    logic evict_inc;
    logic wb_dirty;
    logic dirty_add;
  } stat_ev_t;

endpackage

>>> sv/sact_in_if.sv
// Access channel: one load or store address per item.
`timescale 1ns / 1ps
interface sact_in_if;
  import sact_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink (input valid, input cmd, input address, output ready);
endinterface

>>> sv/sact_out_if.sv
// Result channel: lookup outcome and running statistics.
`timescale 1ns / 1ps
interface sact_out_if;
  import sact_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 evicted;
  logic                 evicted_dirty;
  logic [WAY_OUT_W-1:0] way;
  logic [OUT_CNT_W-1:0] hit_count;
  logic [OUT_CNT_W-1:0] miss_count;
  logic [OUT_CNT_W-1:0] eviction_count;
  logic [DIRTY_W-1:0]   dirty_byte_count;
  logic [OUT_CNT_W-1:0] evicted_byte_count;

  modport source (
    output valid, output hit, output evicted, output evicted_dirty, output way,
    output hit_count, output miss_count, output eviction_count,
    output dirty_byte_count, output evicted_byte_count,
    input ready
  );
  modport sink (
    input valid, input hit, input evicted, input evicted_dirty, input way,
    input hit_count, input miss_count, input eviction_count,
    input dirty_byte_count, input evicted_byte_count,
    output ready
  );
endinterface

>>> sv/sact_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface sact_cfg_if;
  import sact_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/sact_stats.sv
// Saturating hit, miss, eviction and byte counters of the cache directory.
`timescale 1ns / 1ps
module sact_stats #(
  parameter int COUNTER_WIDTH = sact_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sact_pkg::stat_ev_t            ev,
  input  logic [sact_pkg::BLK_W-1:0]    blk,
  output logic [sact_pkg::OUT_CNT_W-1:0] hit_count,
  output logic [sact_pkg::OUT_CNT_W-1:0] miss_count,
  output logic [sact_pkg::OUT_CNT_W-1:0] eviction_count,
  output logic [sact_pkg::DIRTY_W-1:0]   dirty_byte_count,
  output logic [sact_pkg::OUT_CNT_W-1:0] evicted_byte_count
);
  import sact_pkg::*;

  localparam int SUM_W = ((COUNTER_WIDTH > BLK_W) ? COUNTER_WIDTH : BLK_W) + 1;
  localparam int XW    = (COUNTER_WIDTH > OUT_CNT_W) ? COUNTER_WIDTH : OUT_CNT_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [DIRTY_W-1:0]       DIRTY_MAX = '1;

  logic [COUNTER_WIDTH-1:0] hits_r, hits_nxt;
  logic [COUNTER_WIDTH-1:0] misses_r, misses_nxt;
  logic [COUNTER_WIDTH-1:0] evicts_r, evicts_nxt;
  logic [COUNTER_WIDTH-1:0] wb_bytes_r, wb_bytes_nxt;
  logic [DIRTY_W-1:0]       dirty_r, dirty_nxt;
  logic [SUM_W-1:0]         wb_sum;
  logic [DIRTY_W:0]         dirty_sum;
  logic [DIRTY_W-1:0]       blk_d;
  logic [XW-1:0]            hits_x, misses_x, evicts_x, wb_x;

  assign blk_d     = DIRTY_W'(blk);
  assign wb_sum    = SUM_W'(wb_bytes_r) + SUM_W'(blk);
  assign dirty_sum = (DIRTY_W + 1)'(dirty_r) + (DIRTY_W + 1)'(blk);

  always_comb begin
    hits_nxt     = hits_r;
    misses_nxt   = misses_r;
    evicts_nxt   = evicts_r;
    wb_bytes_nxt = wb_bytes_r;
    dirty_nxt    = dirty_r;
    if (ev.hit_inc && hits_r != CNT_MAX) begin
      hits_nxt = hits_r + 1'b1;
    end
    if (ev.miss_inc && misses_r != CNT_MAX) begin
      misses_nxt = misses_r + 1'b1;
    end
    if (ev.evict_inc && evicts_r != CNT_MAX) begin
      evicts_nxt = evicts_r + 1'b1;
    end
    if (ev.wb_dirty) begin
      wb_bytes_nxt = (wb_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : wb_sum[COUNTER_WIDTH-1:0];
      // drop the written-back line from the dirty total, floor at zero
      dirty_nxt = (dirty_r > blk_d) ? dirty_r - blk_d : '0;
    end else if (ev.dirty_add) begin
      dirty_nxt = dirty_sum[DIRTY_W] ? DIRTY_MAX : dirty_sum[DIRTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r     <= '0;
      misses_r   <= '0;
      evicts_r   <= '0;
      wb_bytes_r <= '0;
      dirty_r    <= '0;
    end else begin
      hits_r     <= hits_nxt;
      misses_r   <= misses_nxt;
      evicts_r   <= evicts_nxt;
      wb_bytes_r <= wb_bytes_nxt;
      dirty_r    <= dirty_nxt;
    end
  end

  assign hits_x   = XW'(hits_r);
  assign misses_x = XW'(misses_r);
  assign evicts_x = XW'(evicts_r);
  assign wb_x     = XW'(wb_bytes_r);

  assign hit_count          = hits_x[OUT_CNT_W-1:0];
  assign miss_count         = misses_x[OUT_CNT_W-1:0];
  assign eviction_count     = evicts_x[OUT_CNT_W-1:0];
  assign evicted_byte_count = wb_x[OUT_CNT_W-1:0];
  assign dirty_byte_count   = dirty_r;

endmodule

>>> sv/set_assoc_cache_tag_model.sv
// Top level: set-associative cache directory with write-back and true LRU.
//
//   channel   dir  handshake       payload
//   in_bus    in   valid / ready   cmd, address
//   out_bus   out  valid / ready   hit, evicted, evicted_dirty, way, counters
//   cfg_bus   in   valid / ready   index, data
//
// An item runs from acceptance through FETCH, CMP once per way scanned (1 up to ways in
// use, stopping at the first hit), UPD, ADD and FIN, which registers the result once the
// previous result has gone: one tag RAM read and one compare per way through a single
// comparator. The next item is taken the cycle after the result is loaded.
// After reset a clearing pass zeroes the line state of all 2**MAX_SET_BITS sets; no item
// is taken meanwhile, configuration writes are.
// A stalled result holds in the output register; the sequencer waits for it to drain.
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_model_macros.svh"
module set_assoc_cache_tag_model #(
  parameter int MAX_SET_BITS  = sact_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS      = sact_pkg::MAX_WAYS_DEF,
  parameter int COUNTER_WIDTH = sact_pkg::COUNTER_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sact_in_if.sink    in_bus,
  sact_out_if.source out_bus,
  sact_cfg_if.sink   cfg_bus
);
  import sact_pkg::*;

  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SETS    = 1 << MAX_SET_BITS;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W  = WAY_W;
  localparam int NW_W    = $clog2(MAX_WAYS + 1);
  localparam int KX_W    = NW_W + 1;
  localparam int LINE_AW = SET_W + WAY_W;
  localparam int WX_W    = (WAY_W > WAY_OUT_W) ? WAY_W : WAY_OUT_W;
  localparam int SH_W    = 6;
  localparam logic [RANK_W-1:0] RANK_OLD = RANK_W'(MAX_WAYS - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_UPD   = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  typedef logic [MAX_WAYS-1:0][RANK_W-1:0] rank_row_t;

  // configuration
  logic [SET_BITS_W-1:0]    cfg_set_bits_r;
  logic [OFFSET_BITS_W-1:0] cfg_offset_bits_r;
  logic [WAYS_USED_W-1:0]   cfg_ways_used_r;

  // sequencer
  state_t             state_r, state_nxt;
  logic               store_r, store_nxt;
  logic [ADDR_W-1:0]  tag_r, tag_nxt;
  logic [SET_W-1:0]   set_r, set_nxt;
  logic [4:0]         ob_r, ob_nxt;
  logic [NW_W-1:0]    nw_r, nw_nxt;
  logic [WAY_W-1:0]   k_r, k_nxt;
  logic               hit_r, hit_nxt;
  logic [WAY_W-1:0]   way_r, way_nxt;
  logic               inv_found_r, inv_found_nxt;
  logic [WAY_W-1:0]   inv_way_r, inv_way_nxt;
  logic [WAY_W-1:0]   best_way_r, best_way_nxt;
  logic [RANK_W-1:0]  best_rank_r, best_rank_nxt;
  logic               evict_r, evict_nxt;
  logic               evd_r, evd_nxt;
  logic               dirty_add_r, dirty_add_nxt;
  logic [SET_W-1:0]   clr_idx_r, clr_idx_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_evicted_r, out_evd_r;
  logic [WAY_OUT_W-1:0] out_way_r;
  logic [OUT_CNT_W-1:0] out_hits_r, out_misses_r, out_evicts_r, out_wb_r;
  logic [DIRTY_W-1:0]   out_dirty_r;
  logic                 out_load;

  // memories
  logic [ADDR_W-1:0]   tag_mem [2**LINE_AW];
  logic [ADDR_W-1:0]   tag_rdata_r;
  logic [LINE_AW-1:0]  tag_raddr, tag_waddr;
  logic                tag_we;
  logic [MAX_WAYS-1:0] vld_mem [SETS];
  logic [MAX_WAYS-1:0] dty_mem [SETS];
  rank_row_t           rank_mem [SETS];
  logic [MAX_WAYS-1:0] vld_q_r, dty_q_r;
  rank_row_t           rank_q_r;
  logic                meta_we;
  logic [SET_W-1:0]    meta_waddr;
  logic [MAX_WAYS-1:0] vld_w, dty_w;
  rank_row_t           rank_w;

  // address split
  logic [3:0]          sb_c;
  logic [4:0]          ob_c;
  logic [NW_W-1:0]     nw_c;
  logic [4:0]          wu5;
  logic [SH_W-1:0]     shamt;
  logic [ADDR_W-1:0]   blk_addr;
  logic [SET_W-1:0]    set_mask;

  // scan and update
  logic                cur_v;
  logic [RANK_W-1:0]   cur_rank;
  logic                scan_last;
  logic [WAY_W-1:0]    way_sel;
  logic                sel_v, sel_d;
  logic [RANK_W-1:0]   sel_rank, touch_rank;
  logic                accept;
  stat_ev_t            ev;
  logic [BLK_W-1:0]    blk;
  logic [WX_W-1:0]     way_x;

  logic [OUT_CNT_W-1:0] st_hits, st_misses, st_evicts, st_wb;
  logic [DIRTY_W-1:0]   st_dirty;

  // configuration registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_set_bits_r    <= SET_BITS_RST;
      cfg_offset_bits_r <= OFFSET_BITS_RST;
      cfg_ways_used_r   <= WAYS_USED_RST;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_reg_t'(cfg_bus.index))
        CFG_SET_BITS:    cfg_set_bits_r    <= cfg_bus.data[SET_BITS_W-1:0];
        CFG_OFFSET_BITS: cfg_offset_bits_r <= cfg_bus.data[OFFSET_BITS_W-1:0];
        CFG_WAYS_USED:   cfg_ways_used_r   <= cfg_bus.data[WAYS_USED_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the configuration and split the incoming address
  always_comb begin
    sb_c = ({1'b0, cfg_set_bits_r} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                       : {1'b0, cfg_set_bits_r};
    ob_c = (cfg_offset_bits_r > 5'(MAX_OFFSET_BITS)) ? 5'(MAX_OFFSET_BITS)
                                                     : cfg_offset_bits_r;
    wu5 = {1'b0, cfg_ways_used_r};
    if (wu5 == 5'd0) begin
      nw_c = NW_W'(1);
    end else if (wu5 > 5'(MAX_WAYS)) begin
      nw_c = NW_W'(MAX_WAYS);
    end else begin
      nw_c = wu5[NW_W-1:0];
    end
    shamt    = SH_W'(sb_c) + SH_W'(ob_c);
    blk_addr = in_bus.address >> ob_c;
    set_mask = ~({SET_W{1'b1}} << sb_c);
  end

  assign accept       = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);

  // one way per cycle through the comparator
  assign cur_v     = vld_q_r[k_r];
  assign cur_rank  = rank_q_r[k_r];
  assign scan_last = (KX_W'(k_r) + KX_W'(1)) == KX_W'(nw_r);

  always_comb begin
    if (hit_r) begin
      way_sel = way_r;
    end else if (inv_found_r) begin
      way_sel = inv_way_r;
    end else begin
      way_sel = best_way_r;
    end
  end

  assign sel_v      = vld_q_r[way_sel];
  assign sel_d      = dty_q_r[way_sel];
  assign sel_rank   = rank_q_r[way_sel];
  assign touch_rank = sel_v ? sel_rank : RANK_OLD;

  // new row of line state for the touched set
  always_comb begin
    vld_w  = vld_q_r;
    dty_w  = dty_q_r;
    rank_w = rank_q_r;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (WAY_W'(k) != way_sel && NW_W'(k) < nw_r && vld_q_r[k] &&
          rank_q_r[k] < touch_rank && rank_q_r[k] < RANK_OLD) begin
        rank_w[k] = rank_q_r[k] + 1'b1;
      end
    end
    vld_w[way_sel]  = 1'b1;
    dty_w[way_sel]  = hit_r ? (sel_d | store_r) : store_r;
    rank_w[way_sel] = '0;
  end

  always_comb begin
    state_nxt     = state_r;
    store_nxt     = store_r;
    tag_nxt       = tag_r;
    set_nxt       = set_r;
    ob_nxt        = ob_r;
    nw_nxt        = nw_r;
    k_nxt         = k_r;
    hit_nxt       = hit_r;
    way_nxt       = way_r;
    inv_found_nxt = inv_found_r;
    inv_way_nxt   = inv_way_r;
    best_way_nxt  = best_way_r;
    best_rank_nxt = best_rank_r;
    evict_nxt     = evict_r;
    evd_nxt       = evd_r;
    dirty_add_nxt = dirty_add_r;
    clr_idx_nxt   = clr_idx_r;
    tag_we        = 1'b0;
    meta_we       = 1'b0;
    out_load      = 1'b0;
    ev            = '0;
    case (state_r)
      S_CLEAR: begin
        meta_we     = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SET_W'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          store_nxt = (in_bus.cmd == CMD_STORE);
          tag_nxt   = in_bus.address >> shamt;
          set_nxt   = blk_addr[SET_W-1:0] & set_mask;
          ob_nxt    = ob_c;
          nw_nxt    = nw_c;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        k_nxt         = '0;
        hit_nxt       = 1'b0;
        inv_found_nxt = 1'b0;
        state_nxt     = S_CMP;
      end
      S_CMP: begin
        if (!cur_v && !inv_found_r) begin
          inv_found_nxt = 1'b1;
          inv_way_nxt   = k_r;
        end
        if (k_r == '0 || cur_rank > best_rank_r) begin
          best_way_nxt  = k_r;
          best_rank_nxt = cur_rank;
        end
        if (cur_v && tag_rdata_r == tag_r) begin
          hit_nxt   = 1'b1;
          way_nxt   = k_r;
          state_nxt = S_UPD;
        end else if (scan_last) begin
          state_nxt = S_UPD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_UPD: begin
        meta_we       = 1'b1;
        tag_we        = !hit_r;
        evict_nxt     = !hit_r && !inv_found_r;
        evd_nxt       = !hit_r && !inv_found_r && sel_d;
        dirty_add_nxt = hit_r ? (store_r && !sel_d) : store_r;
        way_nxt       = way_sel;
        ev.hit_inc    = hit_r;
        ev.miss_inc   = !hit_r;
        ev.evict_inc  = !hit_r && !inv_found_r;
        ev.wb_dirty   = !hit_r && !inv_found_r && sel_d;
        state_nxt     = S_ADD;
      end
      S_ADD: begin
        ev.dirty_add = dirty_add_r;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        // hold until the previous result has gone
        if (!out_valid_r || out_bus.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r     <= store_nxt;
    tag_r       <= tag_nxt;
    set_r       <= set_nxt;
    ob_r        <= ob_nxt;
    nw_r        <= nw_nxt;
    k_r         <= k_nxt;
    hit_r       <= hit_nxt;
    way_r       <= way_nxt;
    inv_found_r <= inv_found_nxt;
    inv_way_r   <= inv_way_nxt;
    best_way_r  <= best_way_nxt;
    best_rank_r <= best_rank_nxt;
    evict_r     <= evict_nxt;
    evd_r       <= evd_nxt;
    dirty_add_r <= dirty_add_nxt;
  end

  // tag RAM: one read and one write port, registered read
  assign tag_raddr = {set_r, k_nxt};
  assign tag_waddr = {set_r, way_sel};

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_r;
    end
    tag_rdata_r <= tag_mem[tag_raddr];
  end

  // line state RAM, one row per set; the clearing pass writes zero rows
  assign meta_waddr = (state_r == S_CLEAR) ? clr_idx_r : set_r;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      if (state_r == S_CLEAR) begin
        vld_mem[meta_waddr]  <= '0;
        dty_mem[meta_waddr]  <= '0;
        rank_mem[meta_waddr] <= '0;
      end else begin
        vld_mem[meta_waddr]  <= vld_w;
        dty_mem[meta_waddr]  <= dty_w;
        rank_mem[meta_waddr] <= rank_w;
      end
    end
    vld_q_r  <= vld_mem[set_r];
    dty_q_r  <= dty_mem[set_r];
    rank_q_r <= rank_mem[set_r];
  end

  // statistics
  assign blk = BLK_W'(1) << ob_r;

  sact_stats #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_stats (
    .clk                (clk),
    .rst_n              (rst_n),
    .ev                 (ev),
    .blk                (blk),
    .hit_count          (st_hits),
    .miss_count         (st_misses),
    .eviction_count     (st_evicts),
    .dirty_byte_count   (st_dirty),
    .evicted_byte_count (st_wb)
  );

  // result register
  assign way_x = WX_W'(way_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r     <= hit_r;
      out_evicted_r <= evict_r;
      out_evd_r     <= evd_r;
      out_way_r     <= way_x[WAY_OUT_W-1:0];
      out_hits_r    <= st_hits;
      out_misses_r  <= st_misses;
      out_evicts_r  <= st_evicts;
      out_dirty_r   <= st_dirty;
      out_wb_r      <= st_wb;
    end
  end

  assign out_bus.valid              = out_valid_r;
  assign out_bus.hit                = out_hit_r;
  assign out_bus.evicted            = out_evicted_r;
  assign out_bus.evicted_dirty      = out_evd_r;
  assign out_bus.way                = out_way_r;
  assign out_bus.hit_count          = out_hits_r;
  assign out_bus.miss_count         = out_misses_r;
  assign out_bus.eviction_count     = out_evicts_r;
  assign out_bus.dirty_byte_count   = out_dirty_r;
  assign out_bus.evicted_byte_count = out_wb_r;

  `SACT_ASSERT_NEXT(a_accept_fetch, accept, state_r == S_FETCH, "accepted item did not start a lookup")
  `SACT_ASSERT_SAME(a_scan_bound, state_r == S_CMP, KX_W'(k_r) < KX_W'(nw_r), "way scan ran past ways in use")
  `SACT_ASSERT_SAME(a_evict_on_miss, out_valid_r && out_evicted_r, !out_hit_r, "eviction reported on a hit")
  `SACT_ASSERT_SAME(a_wb_needs_evict, out_valid_r && out_evd_r, out_evicted_r, "dirty write-back without eviction")
  `SACT_ASSERT_SAME(a_clear_blocks, state_r == S_CLEAR, !in_bus.ready, "item taken during clearing pass")

endmodule

>>> tb/set_assoc_cache_tag_model_tb.sv
// Self-checking testbench for the set-associative cache directory.
`timescale 1ns / 1ps
module set_assoc_cache_tag_model_tb;
  import sact_pkg::*;

  localparam int          SETTLE_CYCLES  = 16;
  localparam int          TAIL_CYCLES    = 40;
  localparam int          LINE_COUNT     = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;
  localparam logic [63:0] COUNT_LIMIT    = (64'd1 << COUNTER_WIDTH_DEF) - 64'd1;
  localparam logic [63:0] DIRTY_LIMIT    = (64'd1 << DIRTY_W) - 64'd1;
  localparam logic [1:0]  CFG_UNUSED_IDX = 2'd3;

  typedef struct {
    bit                    is_cfg;
    bit                    drain;
    cmd_t                  cmd;
    logic [ADDR_W-1:0]     address;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
  } access_plan_t;

  typedef struct {
    logic                 hit;
    logic                 evicted;
    logic                 evicted_dirty;
    logic [WAY_OUT_W-1:0] way;
    logic [OUT_CNT_W-1:0] hit_count;
    logic [OUT_CNT_W-1:0] miss_count;
    logic [OUT_CNT_W-1:0] eviction_count;
    logic [DIRTY_W-1:0]   dirty_byte_count;
    logic [OUT_CNT_W-1:0] evicted_byte_count;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sact_in_if  in_bus ();
  sact_out_if out_bus ();
  sact_cfg_if cfg_bus ();

  set_assoc_cache_tag_model dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always #1 clk = ~clk;

  // Directory copy kept by the predictor
  logic [63:0] dir_tag   [LINE_COUNT];
  bit          dir_valid [LINE_COUNT];
  bit          dir_dirty [LINE_COUNT];
  logic [2:0]  dir_age   [LINE_COUNT];
  logic [63:0] cnt_hits, cnt_misses, cnt_evicts, dirty_held, wb_bytes;
  logic [2:0]  cfg_sets;
  logic [4:0]  cfg_offs;
  logic [3:0]  cfg_ways;

  access_plan_t   access_plan[$];
  lookup_result_t predicted_results[$];

  int n_fail = 0;
  int send_gap, quiet_cycles, recv_stall;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    if (a > lim || b > lim - a) return lim;
    return a + b;
  endfunction

  function automatic int eff_set_bits(logic [2:0] v);
    return (v > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(v);
  endfunction

  function automatic int eff_offset_bits(logic [4:0] v);
    return (v > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : int'(v);
  endfunction

  function automatic int eff_ways(logic [3:0] v);
    if (v == 0) return 1;
    return (v > MAX_WAYS_DEF) ? MAX_WAYS_DEF : int'(v);
  endfunction

  // Random gap between items, with calm stretches of no idling now and then
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SET_BITS:    cfg_sets = data[2:0];
      CFG_OFFSET_BITS: cfg_offs = data[4:0];
      CFG_WAYS_USED:   cfg_ways = data[3:0];
      default: ;
    endcase
  endfunction

  function automatic lookup_result_t lookup_access(logic store, logic [63:0] addr);
    lookup_result_t res;
    int             sb, ob, nw, base, way, best, k, rank;
    bit             hit, ev, evd, found;
    logic [63:0]    tag, blk;
    sb    = eff_set_bits(cfg_sets);
    ob    = eff_offset_bits(cfg_offs);
    nw    = eff_ways(cfg_ways);
    blk   = 64'd1 << ob;
    tag   = addr >> (sb + ob);
    base  = int'((addr >> ob) & ((64'd1 << sb) - 64'd1)) * MAX_WAYS_DEF;
    hit   = 1'b0;
    ev    = 1'b0;
    evd   = 1'b0;
    found = 1'b0;
    way   = 0;
    for (k = 0; k < nw; k++) begin
      if (!hit && dir_valid[base + k] && dir_tag[base + k] == tag) begin
        hit = 1'b1;
        way = k;
      end
    end
    if (hit) begin
      cnt_hits = sat_add(cnt_hits, 64'd1, COUNT_LIMIT);
      if (store && !dir_dirty[base + way]) begin
        dir_dirty[base + way] = 1'b1;
        dirty_held = sat_add(dirty_held, blk, DIRTY_LIMIT);
      end
    end else begin
      cnt_misses = sat_add(cnt_misses, 64'd1, COUNT_LIMIT);
      for (k = 0; k < nw; k++) begin
        if (!found && !dir_valid[base + k]) begin
          found = 1'b1;
          way = k;
        end
      end
      if (!found) begin
        // Oldest line goes, lowest way on a tie
        best = 0;
        for (k = 1; k < nw; k++)
          if (dir_age[base + k] > dir_age[base + best]) best = k;
        way = best;
        ev = 1'b1;
        cnt_evicts = sat_add(cnt_evicts, 64'd1, COUNT_LIMIT);
        if (dir_dirty[base + way]) begin
          evd = 1'b1;
          wb_bytes = sat_add(wb_bytes, blk, COUNT_LIMIT);
          dirty_held = (dirty_held > blk) ? dirty_held - blk : 64'd0;
        end
      end
      dir_tag[base + way]   = tag;
      dir_dirty[base + way] = store;
      if (store) dirty_held = sat_add(dirty_held, blk, DIRTY_LIMIT);
    end
    // Age the younger lines; an invalid line counts as the oldest
    rank = dir_valid[base + way] ? int'(dir_age[base + way]) : MAX_WAYS_DEF - 1;
    for (k = 0; k < nw; k++) begin
      if (k != way && dir_valid[base + k] && dir_age[base + k] < rank &&
          dir_age[base + k] < MAX_WAYS_DEF - 1)
        dir_age[base + k] = dir_age[base + k] + 3'd1;
    end
    dir_age[base + way]   = 3'd0;
    dir_valid[base + way] = 1'b1;

    res.hit                = hit;
    res.evicted            = ev;
    res.evicted_dirty      = evd;
    res.way                = way[WAY_OUT_W-1:0];
    res.hit_count          = cnt_hits[OUT_CNT_W-1:0];
    res.miss_count         = cnt_misses[OUT_CNT_W-1:0];
    res.eviction_count     = cnt_evicts[OUT_CNT_W-1:0];
    res.dirty_byte_count   = dirty_held[DIRTY_W-1:0];
    res.evicted_byte_count = wb_bytes[OUT_CNT_W-1:0];
    return res;
  endfunction

  task automatic add_access(cmd_t cmd, logic [63:0] addr, bit drain);
    access_plan_t p;
    p.is_cfg   = 1'b0;
    p.drain    = drain;
    p.cmd      = cmd;
    p.address  = addr;
    p.reg_idx  = '0;
    p.reg_data = '0;
    access_plan.push_back(p);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    access_plan_t p;
    p.is_cfg   = 1'b1;
    p.drain    = 1'b1;
    p.cmd      = CMD_LOAD;
    p.address  = '0;
    p.reg_idx  = idx;
    p.reg_data = data;
    access_plan.push_back(p);
  endtask

  // One setting of the registers followed by a working set of hot sets and tags
  task automatic add_phase(logic [2:0] sets_v, logic [4:0] offs_v, logic [3:0] ways_v,
                           int n_items);
    logic [63:0] region[16];
    int          hot_set[4];
    int          sb, ob, nw, n_reg, n_hot, i, sel;
    logic [63:0] addr, low_mask, set_v, off_v;
    add_cfg(CFG_SET_BITS, {5'($urandom), sets_v});
    add_cfg(CFG_OFFSET_BITS, {3'($urandom), offs_v});
    add_cfg(CFG_WAYS_USED, {4'($urandom), ways_v});
    sb       = eff_set_bits(sets_v);
    ob       = eff_offset_bits(offs_v);
    nw       = eff_ways(ways_v);
    low_mask = (64'd1 << (sb + ob)) - 64'd1;
    n_reg    = nw + $urandom_range(0, 3);
    n_hot    = $urandom_range(1, 4);
    for (i = 0; i < n_reg; i++) region[i] = {$urandom, $urandom};
    for (i = 0; i < n_hot; i++) hot_set[i] = $urandom_range(0, (1 << sb) - 1);
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        addr = {$urandom, $urandom};
      end else begin
        sel   = $urandom_range(0, n_hot - 1);
        set_v = 64'(hot_set[sel]);
        off_v = {$urandom, $urandom} & ((64'd1 << ob) - 64'd1);
        addr  = (region[$urandom_range(0, n_reg - 1)] & ~low_mask) | (set_v << ob) | off_v;
      end
      add_access(cmd_t'($urandom_range(0, 1)), addr, $urandom_range(0, 149) == 0);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // Driver: one plan entry at a time, configuration writes only once drained
  always @(posedge clk) begin
    access_plan_t nxt;
    logic         v_in, v_cfg;
    int           g, q;
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      cfg_bus.valid <= 1'b0;
      send_gap      <= 0;
      quiet_cycles  <= 0;
    end else begin
      v_in  = in_bus.valid;
      v_cfg = cfg_bus.valid;
      g     = send_gap;
      if (in_bus.valid && in_bus.ready) begin
        predicted_results.push_back(lookup_access(in_bus.cmd, in_bus.address));
        v_in = 1'b0;
        g    = draw_gap(send_calm);
      end else if (cfg_bus.valid && cfg_bus.ready) begin
        apply_cfg(cfg_bus.index, cfg_bus.data);
        v_cfg = 1'b0;
        g     = draw_gap(send_calm);
      end else if (!v_in && !v_cfg && g > 0) begin
        g = g - 1;
      end
      q = (predicted_results.size() == 0) ? quiet_cycles + 1 : 0;
      if (!v_in && !v_cfg && g == 0 && access_plan.size() != 0) begin
        nxt = access_plan[0];
        if (!nxt.drain || q >= SETTLE_CYCLES) begin
          void'(access_plan.pop_front());
          if (nxt.is_cfg) begin
            v_cfg         = 1'b1;
            cfg_bus.index <= nxt.reg_idx;
            cfg_bus.data  <= nxt.reg_data;
          end else begin
            v_in           = 1'b1;
            in_bus.cmd     <= nxt.cmd;
            in_bus.address <= nxt.address;
          end
        end
      end
      in_bus.valid  <= v_in;
      cfg_bus.valid <= v_cfg;
      send_gap      <= g;
      quiet_cycles  <= q;
    end
  end

  // Monitor: compare each result item with the oldest prediction, stall at random
  always @(posedge clk) begin
    lookup_result_t want;
    int             st;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_stall    <= 0;
    end else begin
      st = (recv_stall > 0) ? recv_stall - 1 : 0;
      if (out_bus.valid && out_bus.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result item with no access outstanding");
          n_fail++;
        end else begin
          want = predicted_results.pop_front();
          check_field("hit", 64'(want.hit), 64'(out_bus.hit));
          check_field("evicted", 64'(want.evicted), 64'(out_bus.evicted));
          check_field("evicted_dirty", 64'(want.evicted_dirty),
                      64'(out_bus.evicted_dirty));
          check_field("way", 64'(want.way), 64'(out_bus.way));
          check_field("hit_count", 64'(want.hit_count), 64'(out_bus.hit_count));
          check_field("miss_count", 64'(want.miss_count), 64'(out_bus.miss_count));
          check_field("eviction_count", 64'(want.eviction_count),
                      64'(out_bus.eviction_count));
          check_field("dirty_byte_count", 64'(want.dirty_byte_count),
                      64'(out_bus.dirty_byte_count));
          check_field("evicted_byte_count", 64'(want.evicted_byte_count),
                      64'(out_bus.evicted_byte_count));
        end
        st = draw_gap(recv_calm);
      end
      recv_stall    <= st;
      out_bus.ready <= (st == 0);
    end
  end

  initial begin
    int i;
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.cmd      = CMD_LOAD;
    in_bus.address  = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = '0;
    cfg_bus.data    = '0;
    out_bus.ready   = 1'b0;
    for (i = 0; i < LINE_COUNT; i++) begin
      dir_tag[i]   = '0;
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      dir_age[i]   = '0;
    end
    cnt_hits    = '0;
    cnt_misses  = '0;
    cnt_evicts  = '0;
    dirty_held  = '0;
    wb_bytes    = '0;
    cfg_sets    = SET_BITS_RST;
    cfg_offs    = OFFSET_BITS_RST;
    cfg_ways    = WAYS_USED_RST;

    // Reset geometry: fill set 0, hit, dirty it, then evict dirty and clean lines
    add_access(CMD_LOAD, 64'h0, 1'b0);
    add_access(CMD_LOAD, 64'h0, 1'b0);
    add_access(CMD_STORE, 64'h4, 1'b0);
    add_access(CMD_STORE, 64'hF, 1'b0);
    add_access(CMD_LOAD, 64'h100, 1'b0);
    add_access(CMD_STORE, 64'h200, 1'b0);
    add_access(CMD_LOAD, 64'h300, 1'b0);
    add_access(CMD_LOAD, 64'h400, 1'b0);
    add_access(CMD_LOAD, 64'h100, 1'b0);
    add_access(CMD_LOAD, 64'h500, 1'b0);
    add_access(CMD_STORE, 64'h600, 1'b0);
    add_access(CMD_LOAD, 64'h0, 1'b0);
    add_access(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_access(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_access(CMD_LOAD, 64'h8000_0000_0000_0000, 1'b0);
    add_access(CMD_STORE, 64'h7FFF_FFFF_FFFF_FFF0, 1'b1);

    // Extremes first, then settings above the limits and in between
    add_phase(3'd0, 5'd0, 4'd1, 170);
    add_phase(3'd6, 5'd16, 4'd8, 170);
    add_phase(3'd7, 5'd31, 4'd15, 170);
    add_cfg(CFG_UNUSED_IDX, 8'($urandom));
    add_phase(3'd3, 5'd5, 4'd0, 170);
    add_phase(3'd1, 5'd12, 4'd2, 170);
    add_phase(3'd5, 5'd2, 4'd7, 170);
    add_phase(3'd2, 5'd20, 4'd9, 170);
    add_phase(3'd6, 5'd0, 4'd3, 170);
    add_phase(3'd4, 5'd4, 4'd4, 170);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (access_plan.size() != 0 || in_bus.valid || cfg_bus.valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d results never arrived", predicted_results.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("PASS set_assoc_cache_tag_model");
    end else begin
      $display("FAIL set_assoc_cache_tag_model");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("FAIL set_assoc_cache_tag_model");
    $finish;
  end

endmodule
